FILE: sv/lacb_pkg.sv
// ----------------------------------------------------------------------------
// lacb_pkg
// Shared widths and types for the look-at camera basis datapath.
// ----------------------------------------------------------------------------
package lacb_pkg;

  // normalised magnitudes sit below 2^30; the largest in [2^29, 2^30)
  localparam int NORM_BITS = 30;
  // sum of three squared normalised magnitudes
  localparam int SQ_W      = 62;
  // floor square root of a SQ_W-bit value, one root bit per pipeline step
  localparam int ROOT_W    = 31;
  // partial remainder of the root extraction
  localparam int REM_W     = 33;
  // width of every result field
  localparam int OUT_W     = 32;

  typedef logic [NORM_BITS-1:0] norm_t;
  typedef logic [ROOT_W-1:0]    root_t;

endpackage

FILE: sv/lacb_sqrt.sv
// ----------------------------------------------------------------------------
// lacb_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module lacb_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [lacb_pkg::SQ_W-1:0] in_rad,
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_valid,
  output lacb_pkg::root_t           out_root,
  output logic [SIDE_W-1:0]         out_side
);

  localparam int STEPS = lacb_pkg::ROOT_W;
  localparam int SQW   = lacb_pkg::SQ_W;
  localparam int RW    = lacb_pkg::REM_W;

  logic [STEPS-1:0]      v_r;
  logic [SQW-1:0]        rad_r  [STEPS];
  logic [RW-1:0]         rem_r  [STEPS];
  lacb_pkg::root_t       root_r [STEPS];
  logic [SIDE_W-1:0]     side_r [STEPS];

  genvar k;
  for (k = 0; k < STEPS; k++) begin : g_step
    logic              v_i;
    logic [SQW-1:0]    rad_i;
    logic [RW-1:0]     rem_i;
    lacb_pkg::root_t   root_i;
    logic [SIDE_W-1:0] side_i;
    logic [RW+1:0]     rem2;
    logic [RW+1:0]     trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rad_i  = in_rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign side_i = side_r[k-1];
    end

    always_comb begin
      rem2  = {rem_i, rad_i[SQW-1 -: 2]};
      trial = {2'b00, root_i, 2'b01};
      ge    = (rem2 >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? RW'(rem2 - trial) : RW'(rem2);
        root_r[k] <= {root_i[STEPS-2:0], ge};
        rad_r[k]  <= {rad_i[SQW-3:0], 2'b00};
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_root  = root_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

FILE: sv/lacb_div.sv
// ----------------------------------------------------------------------------
// lacb_div
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module lacb_div #(
  parameter int UNIT_FRAC_BITS = 30,
  parameter int SIDE_W         = 1
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         en,
  input  logic                                         in_valid,
  input  logic [lacb_pkg::ROOT_W+UNIT_FRAC_BITS-1:0]   in_num [3],
  input  lacb_pkg::root_t                              in_den,
  input  logic [SIDE_W-1:0]                            in_side,
  output logic                                         out_valid,
  output logic [UNIT_FRAC_BITS:0]                      out_quo [3],
  output logic [SIDE_W-1:0]                            out_side
);

  localparam int QB    = UNIT_FRAC_BITS + 1;
  localparam int RW    = lacb_pkg::ROOT_W;
  localparam int NUM_W = RW + UNIT_FRAC_BITS;

  logic [QB-1:0]     v_r;
  logic [RW-1:0]     rem_r  [QB][3];
  logic [QB-1:0]     low_r  [QB][3];
  logic [QB-1:0]     quo_r  [QB][3];
  lacb_pkg::root_t   den_r  [QB];
  logic [SIDE_W-1:0] side_r [QB];

  genvar k, l;
  for (k = 0; k < QB; k++) begin : g_step
    logic              v_i;
    lacb_pkg::root_t   den_i;
    logic [SIDE_W-1:0] side_i;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign den_i  = den_r[k-1];
      assign side_i = side_r[k-1];
    end

    for (l = 0; l < 3; l++) begin : g_lane
      logic [RW-1:0] rem_i;
      logic [QB-1:0] low_i;
      logic [QB-1:0] quo_i;
      logic [RW:0]   rem2;
      logic          ge;

      if (k == 0) begin : g_first
        assign rem_i = {1'b0, in_num[l][NUM_W-1:QB]};
        assign low_i = in_num[l][QB-1:0];
        assign quo_i = '0;
      end else begin : g_next
        assign rem_i = rem_r[k-1][l];
        assign low_i = low_r[k-1][l];
        assign quo_i = quo_r[k-1][l];
      end

      always_comb begin
        rem2 = {rem_i, low_i[QB-1]};
        ge   = (rem2 >= {1'b0, den_i});
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l] <= ge ? RW'(rem2 - {1'b0, den_i}) : RW'(rem2);
          low_r[k][l] <= {low_i[QB-2:0], 1'b0};
          quo_r[k][l] <= {quo_i[QB-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= den_i;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid  = v_r[QB-1];
  assign out_quo[0] = quo_r[QB-1][0];
  assign out_quo[1] = quo_r[QB-1][1];
  assign out_quo[2] = quo_r[QB-1][2];
  assign out_side   = side_r[QB-1];

endmodule

FILE: sv/lacb_unit.sv
// ----------------------------------------------------------------------------
// lacb_unit
// Pipelined vector normaliser: block-normalise the magnitudes, sum the
// squares, take the root, divide each lane with rounding, restore signs.
// ----------------------------------------------------------------------------
module lacb_unit #(
  parameter int IN_W           = 33,
  parameter int UNIT_FRAC_BITS = 30,
  parameter int SIDE_W         = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [IN_W-1:0]           in_v [3],
  input  logic [SIDE_W-1:0]                in_side,
  output logic                             out_valid,
  output logic signed [UNIT_FRAC_BITS+1:0] out_v [3],
  output logic [SIDE_W-1:0]                out_side
);

  localparam int NB    = lacb_pkg::NORM_BITS;
  localparam int BLW   = $clog2(IN_W + 1);
  localparam int NUM_W = lacb_pkg::ROOT_W + UNIT_FRAC_BITS;
  localparam int OW    = UNIT_FRAC_BITS + 2;
  localparam int SQ_SIDE_W  = 3 * NB + 4 + SIDE_W;
  localparam int DIV_SIDE_W = 4 + SIDE_W;

  // stage A: magnitudes and their maximum
  logic [IN_W-1:0]   mag_c [3];
  logic [IN_W-1:0]   max_c;
  logic              a_v_r;
  logic [IN_W-1:0]   a_mag_r [3];
  logic [IN_W-1:0]   a_max_r;
  logic [2:0]        a_neg_r;
  logic [SIDE_W-1:0] a_side_r;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag_c[l] = in_v[l][IN_W-1] ? IN_W'(~in_v[l] + 1'b1) : IN_W'(in_v[l]);
    end
    max_c = mag_c[0];
    if (mag_c[1] > max_c) max_c = mag_c[1];
    if (mag_c[2] > max_c) max_c = mag_c[2];
  end

  // stage B: bit length of the maximum
  logic [BLW-1:0]    bl_c;
  logic              b_v_r;
  logic [IN_W-1:0]   b_mag_r [3];
  logic [BLW-1:0]    b_bl_r;
  logic [2:0]        b_neg_r;
  logic              b_zero_r;
  logic [SIDE_W-1:0] b_side_r;

  always_comb begin
    bl_c = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (a_max_r[i]) bl_c = BLW'(i + 1);
    end
  end

  // stage C: common shift so the maximum lands in [2^29, 2^30)
  lacb_pkg::norm_t   u_c [3];
  logic              c_v_r;
  lacb_pkg::norm_t   c_u_r [3];
  logic [2:0]        c_neg_r;
  logic              c_zero_r;
  logic [SIDE_W-1:0] c_side_r;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      u_c[l] = NB'({b_mag_r[l], {NB{1'b0}}} >> b_bl_r);
    end
  end

  // stage D: squares
  logic              d_v_r;
  logic [2*NB-1:0]   d_sq_r [3];
  lacb_pkg::norm_t   d_u_r  [3];
  logic [2:0]        d_neg_r;
  logic              d_zero_r;
  logic [SIDE_W-1:0] d_side_r;

  // stage E: sum of squares
  logic                      e_v_r;
  logic [lacb_pkg::SQ_W-1:0] e_sum_r;
  lacb_pkg::norm_t           e_u_r [3];
  logic [2:0]                e_neg_r;
  logic                      e_zero_r;
  logic [SIDE_W-1:0]         e_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        a_mag_r[l] <= mag_c[l];
        a_neg_r[l] <= in_v[l][IN_W-1];
        b_mag_r[l] <= a_mag_r[l];
        c_u_r[l]   <= u_c[l];
        d_sq_r[l]  <= c_u_r[l] * c_u_r[l];
        d_u_r[l]   <= c_u_r[l];
        e_u_r[l]   <= d_u_r[l];
      end
      a_max_r  <= max_c;
      a_side_r <= in_side;
      b_bl_r   <= bl_c;
      b_neg_r  <= a_neg_r;
      b_zero_r <= (a_max_r == '0);
      b_side_r <= a_side_r;
      c_neg_r  <= b_neg_r;
      c_zero_r <= b_zero_r;
      c_side_r <= b_side_r;
      d_neg_r  <= c_neg_r;
      d_zero_r <= c_zero_r;
      d_side_r <= c_side_r;
      e_sum_r  <= lacb_pkg::SQ_W'(d_sq_r[0]) + lacb_pkg::SQ_W'(d_sq_r[1])
                + lacb_pkg::SQ_W'(d_sq_r[2]);
      e_neg_r  <= d_neg_r;
      e_zero_r <= d_zero_r;
      e_side_r <= d_side_r;
    end
  end

  // root of the sum of squares
  logic                  s_v;
  lacb_pkg::root_t       s_root;
  logic [SQ_SIDE_W-1:0]  s_side;

  lacb_sqrt #(
    .SIDE_W (SQ_SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (e_v_r),
    .in_rad    (e_sum_r),
    .in_side   ({e_u_r[0], e_u_r[1], e_u_r[2], e_neg_r, e_zero_r, e_side_r}),
    .out_valid (s_v),
    .out_root  (s_root),
    .out_side  (s_side)
  );

  // stage F: dividend with half the divisor added for rounding
  lacb_pkg::norm_t   s_u [3];
  logic              f_v_r;
  logic [NUM_W-1:0]  f_num_r [3];
  lacb_pkg::root_t   f_den_r;
  logic [DIV_SIDE_W-1:0] f_side_r;

  assign s_u[0] = s_side[SQ_SIDE_W-1 -: NB];
  assign s_u[1] = s_side[SQ_SIDE_W-NB-1 -: NB];
  assign s_u[2] = s_side[SQ_SIDE_W-2*NB-1 -: NB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        f_num_r[l] <= NUM_W'({s_u[l], {UNIT_FRAC_BITS{1'b0}}}) + NUM_W'(s_root >> 1);
      end
      f_den_r  <= s_root;
      f_side_r <= s_side[DIV_SIDE_W-1:0];
    end
  end

  logic                      q_v;
  logic [UNIT_FRAC_BITS:0]   q_quo [3];
  logic [DIV_SIDE_W-1:0]     q_side;

  lacb_div #(
    .UNIT_FRAC_BITS (UNIT_FRAC_BITS),
    .SIDE_W         (DIV_SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_v_r),
    .in_num    (f_num_r),
    .in_den    (f_den_r),
    .in_side   (f_side_r),
    .out_valid (q_v),
    .out_quo   (q_quo),
    .out_side  (q_side)
  );

  // stage G: restore signs, force zero for an all-zero vector
  logic [2:0]            q_neg;
  logic                  q_zero;
  logic                  g_v_r;
  logic signed [OW-1:0]  g_o_r [3];
  logic [SIDE_W-1:0]     g_side_r;

  assign q_neg  = q_side[DIV_SIDE_W-1 -: 3];
  assign q_zero = q_side[SIDE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (en) begin
      g_v_r <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        if (q_zero) begin
          g_o_r[l] <= '0;
        end else if (q_neg[l]) begin
          g_o_r[l] <= OW'(~{1'b0, q_quo[l]} + 1'b1);
        end else begin
          g_o_r[l] <= OW'({1'b0, q_quo[l]});
        end
      end
      g_side_r <= q_side[SIDE_W-1:0];
    end
  end

  assign out_valid = g_v_r;
  assign out_v[0]  = g_o_r[0];
  assign out_v[1]  = g_o_r[1];
  assign out_v[2]  = g_o_r[2];
  assign out_side  = g_side_r;

endmodule

FILE: sv/look_at_camera_basis.sv
// Pipeline: nine top-level stages plus three normaliser pipelines of
//   39 + UNIT_FRAC_BITS stages each.
// Throughput: one word per cycle while no held output word stalls the pipe;
//   the root and divide steps are fully pipelined.
// Reset: synchronous, active low; clears every valid bit, payload is not reset.
// ----------------------------------------------------------------------------
// look_at_camera_basis
// Look-at camera basis: back, right and up axes in Q2.30 and the saturated
// view translation in Q16.16, from a camera position and a target point.
// ----------------------------------------------------------------------------
module look_at_camera_basis #(
  parameter int COORD_WIDTH    = 32,
  parameter int UNIT_FRAC_BITS = 30
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  logic signed [COORD_WIDTH-1:0] in_aim_x,
  input  logic signed [COORD_WIDTH-1:0] in_aim_y,
  input  logic signed [COORD_WIDTH-1:0] in_aim_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_right_x,
  output logic signed [31:0]            out_right_y,
  output logic signed [31:0]            out_right_z,
  output logic signed [31:0]            out_up_x,
  output logic signed [31:0]            out_up_y,
  output logic signed [31:0]            out_up_z,
  output logic signed [31:0]            out_back_x,
  output logic signed [31:0]            out_back_y,
  output logic signed [31:0]            out_back_z,
  output logic signed [31:0]            out_shift_x,
  output logic signed [31:0]            out_shift_y,
  output logic signed [31:0]            out_shift_z
);

  localparam int CW = COORD_WIDTH;
  localparam int UF = UNIT_FRAC_BITS;
  localparam int AW = UF + 2;              // unit axis component
  localparam int PX = 2 * UF + 4;          // product of two axis components
  localparam int YW = 2 * UF + 5;          // cross product component
  localparam int PP = CW + UF + 2;         // position times axis component
  localparam int SW = PP + 2;              // dot product
  localparam int RW = SW + 1;              // negated and rounded dot product
  localparam int OW = lacb_pkg::OUT_W;
  localparam logic signed [AW-1:0] AXIS_ONE = AW'(1) << UF;
  localparam logic signed [OW-1:0] OUT_ONE  = OW'(1) << UF;

  typedef struct packed {
    logic signed [CW-1:0] p0;
    logic signed [CW-1:0] p1;
    logic signed [CW-1:0] p2;
    logic                 dz;
  } zside_t;

  typedef struct packed {
    logic signed [CW-1:0] p0;
    logic signed [CW-1:0] p1;
    logic signed [CW-1:0] p2;
    logic                 dz;
    logic signed [AW-1:0] z0;
    logic signed [AW-1:0] z1;
    logic signed [AW-1:0] z2;
    logic                 vert;
  } xside_t;

  typedef struct packed {
    logic signed [CW-1:0] p0;
    logic signed [CW-1:0] p1;
    logic signed [CW-1:0] p2;
    logic                 dz;
    logic signed [AW-1:0] z0;
    logic signed [AW-1:0] z1;
    logic signed [AW-1:0] z2;
    logic signed [AW-1:0] x0;
    logic signed [AW-1:0] x1;
  } yside_t;

  // One enable for the whole pipe: advance unless the output word is held.
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // --------------------------------------------------------------------------
  // Stage 1: direction from target to position, flag a coincident pair.
  // --------------------------------------------------------------------------
  logic signed [CW:0]   d_c [3];
  logic                 s1_v_r;
  logic signed [CW:0]   s1_d_r [3];
  zside_t               s1_side_r;

  always_comb begin
    d_c[0] = (CW+1)'(in_pos_x) - (CW+1)'(in_aim_x);
    d_c[1] = (CW+1)'(in_pos_y) - (CW+1)'(in_aim_y);
    d_c[2] = (CW+1)'(in_pos_z) - (CW+1)'(in_aim_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r[0]    <= d_c[0];
      s1_d_r[1]    <= d_c[1];
      s1_d_r[2]    <= d_c[2];
      s1_side_r.p0 <= in_pos_x;
      s1_side_r.p1 <= in_pos_y;
      s1_side_r.p2 <= in_pos_z;
      s1_side_r.dz <= (d_c[0] == '0) && (d_c[1] == '0) && (d_c[2] == '0);
    end
  end

  // Back axis: normalise the direction.
  logic                 z_v;
  logic signed [AW-1:0] z_o [3];
  zside_t               z_side;

  lacb_unit #(
    .IN_W           (CW + 1),
    .UNIT_FRAC_BITS (UF),
    .SIDE_W         ($bits(zside_t))
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s1_v_r),
    .in_v      (s1_d_r),
    .in_side   (s1_side_r),
    .out_valid (z_v),
    .out_v     (z_o),
    .out_side  (z_side)
  );

  // --------------------------------------------------------------------------
  // Stage 2: horizontal perpendicular (-Zy, Zx, 0); note a vertical view.
  // --------------------------------------------------------------------------
  logic                 s2_v_r;
  logic signed [AW-1:0] s2_t_r [3];
  xside_t               s2_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_t_r[0]      <= -z_o[1];
      s2_t_r[1]      <= z_o[0];
      s2_t_r[2]      <= '0;
      s2_side_r.p0   <= z_side.p0;
      s2_side_r.p1   <= z_side.p1;
      s2_side_r.p2   <= z_side.p2;
      s2_side_r.dz   <= z_side.dz;
      s2_side_r.z0   <= z_o[0];
      s2_side_r.z1   <= z_o[1];
      s2_side_r.z2   <= z_o[2];
      s2_side_r.vert <= (z_o[0] == '0) && (z_o[1] == '0);
    end
  end

  // Right axis: normalise the perpendicular.
  logic                 x_v;
  logic signed [AW-1:0] x_o [3];
  xside_t               x_side;

  lacb_unit #(
    .IN_W           (AW),
    .UNIT_FRAC_BITS (UF),
    .SIDE_W         ($bits(xside_t))
  ) u_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_v_r),
    .in_v      (s2_t_r),
    .in_side   (s2_side_r),
    .out_valid (x_v),
    .out_v     (x_o),
    .out_side  (x_side)
  );

  // --------------------------------------------------------------------------
  // Stage 3: substitute the unit x axis for a vertical view. The right axis
  // has no z component in either case, so only two lanes travel on.
  // --------------------------------------------------------------------------
  logic                 s3_v_r;
  yside_t               s3_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r.p0 <= x_side.p0;
      s3_side_r.p1 <= x_side.p1;
      s3_side_r.p2 <= x_side.p2;
      s3_side_r.dz <= x_side.dz;
      s3_side_r.z0 <= x_side.z0;
      s3_side_r.z1 <= x_side.z1;
      s3_side_r.z2 <= x_side.z2;
      s3_side_r.x0 <= x_side.vert ? AXIS_ONE : x_o[0];
      s3_side_r.x1 <= x_side.vert ? '0 : x_o[1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: partial products of Z x X.
  // --------------------------------------------------------------------------
  logic                 s4_v_r;
  logic signed [PX-1:0] s4_za_r;   // z2 * x1
  logic signed [PX-1:0] s4_zb_r;   // z2 * x0
  logic signed [PX-1:0] s4_zc_r;   // z0 * x1
  logic signed [PX-1:0] s4_ze_r;   // z1 * x0
  yside_t               s4_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_za_r   <= PX'(s3_side_r.z2) * PX'(s3_side_r.x1);
      s4_zb_r   <= PX'(s3_side_r.z2) * PX'(s3_side_r.x0);
      s4_zc_r   <= PX'(s3_side_r.z0) * PX'(s3_side_r.x1);
      s4_ze_r   <= PX'(s3_side_r.z1) * PX'(s3_side_r.x0);
      s4_side_r <= s3_side_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: combine the cross product terms.
  // --------------------------------------------------------------------------
  logic                 s5_v_r;
  logic signed [YW-1:0] s5_t_r [3];
  yside_t               s5_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_t_r[0] <= -YW'(s4_za_r);
      s5_t_r[1] <= YW'(s4_zb_r);
      s5_t_r[2] <= YW'(s4_zc_r) - YW'(s4_ze_r);
      s5_side_r <= s4_side_r;
    end
  end

  // Up axis: normalise the cross product.
  logic                 y_v;
  logic signed [AW-1:0] y_o [3];
  yside_t               y_side;

  lacb_unit #(
    .IN_W           (YW),
    .UNIT_FRAC_BITS (UF),
    .SIDE_W         ($bits(yside_t))
  ) u_up (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s5_v_r),
    .in_v      (s5_t_r),
    .in_side   (s5_side_r),
    .out_valid (y_v),
    .out_v     (y_o),
    .out_side  (y_side)
  );

  // --------------------------------------------------------------------------
  // Stage 6: position times each axis component, exact.
  // --------------------------------------------------------------------------
  logic                 s6_v_r;
  logic signed [PP-1:0] s6_px_r [2];
  logic signed [PP-1:0] s6_py_r [3];
  logic signed [PP-1:0] s6_pz_r [3];
  logic signed [AW-1:0] s6_y_r  [3];
  yside_t               s6_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_px_r[0] <= PP'(y_side.p0) * PP'(y_side.x0);
      s6_px_r[1] <= PP'(y_side.p1) * PP'(y_side.x1);
      s6_py_r[0] <= PP'(y_side.p0) * PP'(y_o[0]);
      s6_py_r[1] <= PP'(y_side.p1) * PP'(y_o[1]);
      s6_py_r[2] <= PP'(y_side.p2) * PP'(y_o[2]);
      s6_pz_r[0] <= PP'(y_side.p0) * PP'(y_side.z0);
      s6_pz_r[1] <= PP'(y_side.p1) * PP'(y_side.z1);
      s6_pz_r[2] <= PP'(y_side.p2) * PP'(y_side.z2);
      s6_y_r[0]  <= y_o[0];
      s6_y_r[1]  <= y_o[1];
      s6_y_r[2]  <= y_o[2];
      s6_side_r  <= y_side;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: dot products.
  // --------------------------------------------------------------------------
  logic                 s7_v_r;
  logic signed [SW-1:0] s7_dot_r [3];
  logic signed [AW-1:0] s7_y_r   [3];
  yside_t               s7_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_dot_r[0] <= SW'(s6_px_r[0]) + SW'(s6_px_r[1]);
      s7_dot_r[1] <= SW'(s6_py_r[0]) + SW'(s6_py_r[1]) + SW'(s6_py_r[2]);
      s7_dot_r[2] <= SW'(s6_pz_r[0]) + SW'(s6_pz_r[1]) + SW'(s6_pz_r[2]);
      s7_y_r      <= s6_y_r;
      s7_side_r   <= s6_side_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: negate and add half an LSB for round-half-up.
  // --------------------------------------------------------------------------
  localparam logic signed [RW-1:0] HALF_LSB = RW'(1) << (UF - 1);

  logic                 s8_v_r;
  logic signed [RW-1:0] s8_r_r [3];
  logic signed [AW-1:0] s8_y_r [3];
  yside_t               s8_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        s8_r_r[l] <= HALF_LSB - RW'(s7_dot_r[l]);
      end
      s8_y_r    <= s7_y_r;
      s8_side_r <= s7_side_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: drop the fraction, saturate to 32 bits, drive the output word.
  // A coincident position and target yields an all-zero word.
  // --------------------------------------------------------------------------
  logic signed [RW-1:0] sh_c  [3];
  logic signed [OW-1:0] sat_c [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sh_c[l] = s8_r_r[l] >>> UF;
      if ((&sh_c[l][RW-1:OW-1]) || !(|sh_c[l][RW-1:OW-1])) begin
        sat_c[l] = sh_c[l][OW-1:0];
      end else if (sh_c[l][RW-1]) begin
        sat_c[l] = {1'b1, {(OW-1){1'b0}}};
      end else begin
        sat_c[l] = {1'b0, {(OW-1){1'b1}}};
      end
    end
  end

  logic signed [OW-1:0] o_right_x_r, o_right_y_r;
  logic signed [OW-1:0] o_up_x_r, o_up_y_r, o_up_z_r;
  logic signed [OW-1:0] o_back_x_r, o_back_y_r, o_back_z_r;
  logic signed [OW-1:0] o_shift_r [3];
  logic                 o_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (s8_side_r.dz) begin
        o_right_x_r <= '0;
        o_right_y_r <= '0;
        o_up_x_r    <= '0;
        o_up_y_r    <= '0;
        o_up_z_r    <= '0;
        o_back_x_r  <= '0;
        o_back_y_r  <= '0;
        o_back_z_r  <= '0;
        o_shift_r[0] <= '0;
        o_shift_r[1] <= '0;
        o_shift_r[2] <= '0;
      end else begin
        o_right_x_r <= OW'(s8_side_r.x0);
        o_right_y_r <= OW'(s8_side_r.x1);
        o_up_x_r    <= OW'(s8_y_r[0]);
        o_up_y_r    <= OW'(s8_y_r[1]);
        o_up_z_r    <= OW'(s8_y_r[2]);
        o_back_x_r  <= OW'(s8_side_r.z0);
        o_back_y_r  <= OW'(s8_side_r.z1);
        o_back_z_r  <= OW'(s8_side_r.z2);
        o_shift_r[0] <= sat_c[0];
        o_shift_r[1] <= sat_c[1];
        o_shift_r[2] <= sat_c[2];
      end
    end
  end

  // Valid bits for the top-level stages; they advance with the payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= z_v;
      s3_v_r <= x_v;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= y_v;
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
      o_v_r  <= s8_v_r;
    end
  end

  assign out_valid   = o_v_r;
  assign out_right_x = o_right_x_r;
  assign out_right_y = o_right_y_r;
  assign out_right_z = '0;
  assign out_up_x    = o_up_x_r;
  assign out_up_y    = o_up_y_r;
  assign out_up_z    = o_up_z_r;
  assign out_back_x  = o_back_x_r;
  assign out_back_y  = o_back_y_r;
  assign out_back_z  = o_back_z_r;
  assign out_shift_x = o_shift_r[0];
  assign out_shift_y = o_shift_r[1];
  assign out_shift_z = o_shift_r[2];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A zero back axis only comes from a coincident pair, which clears the word.
  a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_back_x == '0) && (out_back_y == '0) && (out_back_z == '0)
    |-> (out_right_x == '0) && (out_up_y == '0) && (out_shift_x == '0)
        && (out_shift_z == '0))
    else $error("zero back axis with non-zero basis");

  // The z components of the back and up axes stay within [-1, 1].
  a_back_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_back_z <= OUT_ONE) && (out_back_z >= -OUT_ONE)
                  && (out_up_z <= OUT_ONE) && (out_up_z >= -OUT_ONE))
    else $error("axis component out of unit range");

  // A held output word keeps the whole pipe frozen.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_shift_y) && $stable(out_up_x))
    else $error("output word changed while held");

endmodule
